@@ sv/bsamp_pkg.sv @@
// Shared types and constants for the bounded uniform sampler.
// No dependencies; used by bsamp_cfg and bounded_uniform_sampler_top.
package bsamp_pkg;

  // Register indexes of the configuration port
  localparam int unsigned REG_BOUND = 0;

  // Status passed from the register block to the datapath
  typedef struct packed {
    logic busy;        // rejection threshold is being computed
    logic small_bound; // bound is zero or one: every result is zero
  } cfg_status_t;

endpackage

@@ sv/bsamp_cfg.sv @@
// Bound register with readback, APB-style write decode and the serial threshold divider.
// Depends on bsamp_pkg.
module bsamp_cfg #(
  parameter int WORD_BITS = 32,
  parameter int DATA_BITS = 32,
  parameter int ADDR_BITS = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_BITS-1:0]    paddr,
  input  logic [DATA_BITS-1:0]    pwdata,
  output logic [DATA_BITS-1:0]    prdata,
  output logic [WORD_BITS-1:0]    bound,
  output logic [WORD_BITS-1:0]    threshold,
  output bsamp_pkg::cfg_status_t  status
);

  localparam int BYTE_STEP   = DATA_BITS / 8;
  localparam int OFFSET_BITS = $clog2(BYTE_STEP);
  localparam int CNT_BITS    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic                 write_en;
  logic [WORD_BITS-1:0] new_bound;
  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] dividend;
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] rem_next;

  // Decode a write transaction to the bound register by its word index
  assign write_en  = psel && penable && pwrite &&
                     (paddr[ADDR_BITS-1:OFFSET_BITS] ==
                      (ADDR_BITS-OFFSET_BITS)'(bsamp_pkg::REG_BOUND));
  assign new_bound = pwdata[WORD_BITS-1:0];

  // One restoring division step on (2^W - bound) per cycle while busy
  always_comb begin
    shifted = {rem, dividend[WORD_BITS-1]};
    diff    = shifted - {1'b0, bound};
    if (shifted >= {1'b0, bound}) begin
      rem_next = diff[WORD_BITS-1:0];
    end else begin
      rem_next = shifted[WORD_BITS-1:0];
    end
  end

  // Hold the bound; start the threshold computation on each write of a bound of two or more
  always_ff @(posedge clk) begin
    if (rst) begin
      bound    <= '0;
      busy     <= 1'b0;
      cnt      <= '0;
      rem      <= '0;
      dividend <= '0;
    end else if (write_en) begin
      bound    <= new_bound;
      busy     <= (new_bound > WORD_BITS'(1));
      cnt      <= '0;
      rem      <= '0;
      dividend <= '0 - new_bound;
    end else if (busy) begin
      rem      <= rem_next;
      dividend <= {dividend[WORD_BITS-2:0], 1'b0};
      cnt      <= cnt + CNT_BITS'(1);
      if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign threshold          = rem;
  assign status.busy        = busy;
  assign status.small_bound = (bound < WORD_BITS'(2));
  assign prdata             = DATA_BITS'(bound);

endmodule

@@ sv/bsamp_div_stage.sv @@
// One pipeline stage of the remainder unit: shifts in one word bit per stage.
// No package dependencies.
module bsamp_div_stage #(
  parameter int WORD_BITS = 32,
  parameter int STAGE     = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WORD_BITS-1:0] bound,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [WORD_BITS-1:0] up_word,
  input  logic [WORD_BITS-1:0] up_rem,
  output logic                 down_valid,
  input  logic                 down_ready,
  output logic [WORD_BITS-1:0] down_word,
  output logic [WORD_BITS-1:0] down_rem
);

  localparam int BIT = WORD_BITS - 1 - STAGE;

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] rem_next;

  // Bring down the next dividend bit and subtract the bound when it fits
  always_comb begin
    shifted = {up_rem, up_word[BIT]};
    diff    = shifted - {1'b0, bound};
    if (shifted >= {1'b0, bound}) begin
      rem_next = diff[WORD_BITS-1:0];
    end else begin
      rem_next = shifted[WORD_BITS-1:0];
    end
  end

  // Take a new transaction when empty or when the next stage moves
  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_word <= up_word;
      down_rem  <= rem_next;
    end
  end

endmodule

@@ sv/bounded_uniform_sampler_top.sv @@
// Bounded uniform sampler: random words in, unbiased values below a bound out.
// Uses bsamp_pkg, bsamp_cfg and bsamp_div_stage.
//
// Usage:
//   Write the bound register at byte address 0 of the APB-style port (4*i
//   addressing for the default 32-bit word). After a write with a bound of two or more
//   the rejection threshold (2^W - bound) mod bound is computed serially
//   by the register block; word_stall is high meanwhile.
//   Random words enter on random_word with word_valid/word_stall. A word below
//   the threshold is accepted and dropped. Every other word leaves on
//   bounded_value with value_valid/value_stall as word mod bound. A bound of
//   zero or one gives zero for every word.
// Timing:
//   One word per cycle sustained while no threshold is computed and value_stall is low.
//   The remainder is a pipeline of WORD_BITS restoring-division stages, one bit per
//   stage; a kept word is registered by each stage in turn, ending on bounded_value.
// Reset and stall:
//   rst clears the bound to zero and empties the pipeline. While the receiver
//   stalls, the last stage holds its result and earlier stages keep filling
//   empty slots; the stall reaches word_stall only once every stage is full.
module bounded_uniform_sampler_top #(
  parameter  int WORD_BITS = 32,
  localparam int DATA_BITS = (WORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  input  logic [WORD_BITS-1:0] random_word,
  input  logic                 word_valid,
  output logic                 word_stall,
  output logic [WORD_BITS-1:0] bounded_value,
  output logic                 value_valid,
  input  logic                 value_stall
);

  logic [WORD_BITS-1:0]   bound;
  logic [WORD_BITS-1:0]   threshold;
  bsamp_pkg::cfg_status_t status;

  logic [WORD_BITS:0]     stg_valid;
  logic [WORD_BITS:0]     stg_ready;
  logic [WORD_BITS-1:0]   stg_word [WORD_BITS+1];
  logic [WORD_BITS-1:0]   stg_rem  [WORD_BITS+1];
  logic                   keep;

  assign pready = 1'b1;

  bsamp_cfg #(
    .WORD_BITS (WORD_BITS),
    .DATA_BITS (DATA_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .bound     (bound),
    .threshold (threshold),
    .status    (status)
  );

  // Drop words below the threshold at the entry; hold input while threshold runs
  assign keep         = status.small_bound || (random_word >= threshold);
  assign word_stall   = status.busy || !stg_ready[0];
  assign stg_valid[0] = word_valid && !status.busy && keep;
  assign stg_word[0]  = random_word;
  assign stg_rem[0]   = '0;

  // Remainder pipeline, one dividend bit per stage
  for (genvar s = 0; s < WORD_BITS; s++) begin : g_stage
    bsamp_div_stage #(
      .WORD_BITS (WORD_BITS),
      .STAGE     (s)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .bound      (bound),
      .up_valid   (stg_valid[s]),
      .up_ready   (stg_ready[s]),
      .up_word    (stg_word[s]),
      .up_rem     (stg_rem[s]),
      .down_valid (stg_valid[s+1]),
      .down_ready (stg_ready[s+1]),
      .down_word  (stg_word[s+1]),
      .down_rem   (stg_rem[s+1])
    );
  end

  // Present the last stage; a bound below two forces zero
  assign stg_ready[WORD_BITS] = !value_stall;
  assign value_valid          = stg_valid[WORD_BITS];
  assign bounded_value        = status.small_bound ? '0 : stg_rem[WORD_BITS];

endmodule

@@ sv/bsamp_checker.sv @@
// Port-level checks for the bounded uniform sampler, bound to the top level.
// Depends only on the ports of bounded_uniform_sampler_top.
module bsamp_checker #(
  parameter  int WORD_BITS = 32,
  localparam int DATA_BITS = (WORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [ADDR_BITS-1:0] paddr,
  input logic [DATA_BITS-1:0] pwdata,
  input logic [DATA_BITS-1:0] prdata,
  input logic                 pready,
  input logic [WORD_BITS-1:0] bounded_value,
  input logic                 value_valid,
  input logic                 value_stall
);

  localparam int OFFSET_BITS = (WORD_BITS > 32) ? 3 : 2;

  logic [WORD_BITS-1:0] shadow;

  // Track the bound from write transactions seen on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_BITS-1:OFFSET_BITS] == '0)) begin
      shadow <= pwdata[WORD_BITS-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_stall |=> value_valid && $stable(bounded_value))
    else $error("stalled result changed or vanished");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    value_valid && (shadow >= WORD_BITS'(2)) |-> bounded_value < shadow)
    else $error("result not below the bound");

  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    value_valid && (shadow < WORD_BITS'(2)) |-> bounded_value == '0)
    else $error("bound below two gave a nonzero result");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    prdata == DATA_BITS'(shadow))
    else $error("bound readback does not match last write");

endmodule

bind bounded_uniform_sampler_top bsamp_checker #(.WORD_BITS(WORD_BITS)) u_bsamp_checker (
  .clk           (clk),
  .rst           (rst),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .bounded_value (bounded_value),
  .value_valid   (value_valid),
  .value_stall   (value_stall)
);
